[src/ngs_pkg.sv]
package ngs_pkg;

  localparam int NGS_STATIONS = 64;
  localparam logic [15:0] NGS_INTERVAL_RESET = 16'd1000;

  localparam int SQ1_K = 26;
  localparam int SQ2_K = 32;
  localparam logic [16:0] METRES_PER_DEG = 17'd111123;
  localparam int DEG_FRAC_BITS = 16;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef struct packed {
    logic               active;
    logic signed [23:0] lat;
    logic signed [24:0] lon;
  } station_t;

endpackage

[src/ngs_station_cell.sv]
module ngs_station_cell
  import ngs_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     load,
  input  logic     shift,
  input  station_t wr_ent,
  input  station_t nb_ent,
  output station_t ent
);

  logic               active;
  logic signed [23:0] lat;
  logic signed [24:0] lon;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (load) begin
      active <= wr_ent.active;
    end else if (shift) begin
      active <= nb_ent.active;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      lat <= wr_ent.lat;
      lon <= wr_ent.lon;
    end else if (shift) begin
      lat <= nb_ent.lat;
      lon <= nb_ent.lon;
    end
  end

  assign ent = '{active: active, lat: lat, lon: lon};

endmodule

[src/ngs_sqrt_cell.sv]
module ngs_sqrt_cell #(
  parameter int K  = 26,
  parameter int TW = 8
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_vld,
  input  logic [K+1:0]    in_rem,
  input  logic [K-1:0]    in_root,
  input  logic [2*K-1:0]  in_rad,
  input  logic [TW-1:0]   in_tag,
  output logic            out_vld,
  output logic [K+1:0]    out_rem,
  output logic [K-1:0]    out_root,
  output logic [2*K-1:0]  out_rad,
  output logic [TW-1:0]   out_tag
);

  logic [K+3:0] rem_s;
  logic [K+3:0] trial;
  logic         fits;

  assign rem_s = {in_rem, in_rad[2*K-1:2*K-2]};
  assign trial = {2'b00, in_root, 2'b01};
  assign fits  = (rem_s >= trial);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    out_rad <= {in_rad[2*K-3:0], 2'b00};
    out_tag <= in_tag;
    if (fits) begin
      out_rem  <= (K+2)'(rem_s - trial);
      out_root <= {in_root[K-2:0], 1'b1};
    end else begin
      out_rem  <= (K+2)'(rem_s);
      out_root <= {in_root[K-2:0], 1'b0};
    end
  end

endmodule

[src/nearest_ground_station_search_core.sv]
// Channel  Direction  Handshake                 Contents
// s_*      in         s_tvalid / s_tready       request item: tuser req_type, tdata fields
// m_*      out        m_tvalid / m_tready       result item: tdata updated, station, range
// cfg_*    in         cfg_valid / cfg_ready     update_interval_ms write data
//
// A write item or a query that does not recompute returns its result in the cycle after it is
// accepted. A recomputing query rotates the station ring through its STATIONS cells, one
// station per cycle, into a pipeline of 64 stages (two bit-per-stage square roots). One item
// is in work at a time; the output register is taken while the next item is accepted. Reset
// clears all stations to inactive at once.
module nearest_ground_station_search_core
  import ngs_pkg::*;
#(
  parameter int STATIONS = NGS_STATIONS
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // [0] req_type
  input  logic [0:0]   s_tuser,
  // [5:0] station_index, [6] station_active, [30:7] station_lat, [55:31] station_lon,
  // [79:56] vehicle_lat, [104:80] vehicle_lon, [136:105] vehicle_alt, [176:137] query_time
  input  logic [183:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // [0] updated, [6:1] closest_station, [38:7] closest_range
  output logic [39:0]  m_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [15:0]  cfg_data
);

  localparam int IW = (STATIONS > 1) ? $clog2(STATIONS) : 1;
  localparam int TW = IW + 2;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SEARCH = 3'b010,
    ST_DRAIN  = 3'b100
  } state_t;

  state_t state;

  logic [15:0] interval;
  logic [39:0] last_time;
  logic [5:0]  held_station;
  logic [31:0] held_range;

  logic               req_type;
  logic [5:0]         station_index;
  station_t           wr_ent;
  logic signed [23:0] vehicle_lat_in;
  logic signed [24:0] vehicle_lon_in;
  logic signed [31:0] vehicle_alt_in;
  logic [39:0]        query_time;

  assign req_type       = s_tuser[0];
  assign station_index  = s_tdata[5:0];
  assign wr_ent.active  = s_tdata[6];
  assign wr_ent.lat     = s_tdata[30:7];
  assign wr_ent.lon     = s_tdata[55:31];
  assign vehicle_lat_in = s_tdata[79:56];
  assign vehicle_lon_in = s_tdata[104:80];
  assign vehicle_alt_in = s_tdata[136:105];
  assign query_time     = s_tdata[176:137];

  logic in_acc;
  logic do_update;

  assign s_tready  = (state == ST_IDLE) && (!m_tvalid || m_tready);
  assign in_acc    = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;
  assign do_update = ({1'b0, last_time} + 41'(interval)) < {1'b0, query_time};

  always_ff @(posedge clk) begin
    if (rst) begin
      interval <= NGS_INTERVAL_RESET;
    end else if (cfg_valid) begin
      interval <= cfg_data;
    end
  end

  // Station ring.
  station_t ring [STATIONS];
  logic     shift;

  assign shift = (state == ST_SEARCH);

  for (genvar i = 0; i < STATIONS; i++) begin : g_ring
    logic load;
    assign load = in_acc && (req_type == REQ_WRITE) && (32'(station_index) == i);
    ngs_station_cell u_cell (
      .clk    (clk),
      .rst    (rst),
      .load   (load),
      .shift  (shift),
      .wr_ent (wr_ent),
      .nb_ent (ring[(i + 1) % STATIONS]),
      .ent    (ring[i])
    );
  end

  // Query operands.
  logic signed [23:0] vlat;
  logic signed [24:0] vlon;
  logic [31:0]        aalt;
  logic [63:0]        alt2;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      vlat <= vehicle_lat_in;
      vlon <= vehicle_lon_in;
      aalt <= vehicle_alt_in[31] ? 32'(-vehicle_alt_in) : 32'(vehicle_alt_in);
    end
    alt2 <= 64'(aalt) * 64'(aalt);
  end

  // Feed counter.
  logic [IW-1:0] cnt;
  logic          feed_last;

  assign feed_last = (cnt == IW'(STATIONS - 1));

  // Front stages: differences, squares, sum.
  logic signed [24:0] dl_lat;
  logic signed [25:0] dl_lon;
  logic               d_vld, q_vld, s_vld;
  logic [TW-1:0]      d_tag, q_tag, s_tag;
  logic [23:0]        d_lat;
  logic [24:0]        d_lon;
  logic [47:0]        q_lat;
  logic [49:0]        q_lon;
  logic [2*SQ1_K-1:0] s_rad;

  assign dl_lat = {ring[0].lat[23], ring[0].lat} - {vlat[23], vlat};
  assign dl_lon = {ring[0].lon[24], ring[0].lon} - {vlon[24], vlon};

  always_ff @(posedge clk) begin
    if (rst) begin
      d_vld <= 1'b0;
      q_vld <= 1'b0;
      s_vld <= 1'b0;
    end else begin
      d_vld <= shift;
      q_vld <= d_vld;
      s_vld <= q_vld;
    end
  end

  always_ff @(posedge clk) begin
    d_tag <= {feed_last, ring[0].active, cnt};
    d_lat <= dl_lat[24] ? 24'(-dl_lat) : 24'(dl_lat);
    d_lon <= dl_lon[25] ? 25'(-dl_lon) : 25'(dl_lon);
    q_tag <= d_tag;
    q_lat <= 48'(d_lat) * 48'(d_lat);
    q_lon <= 50'(d_lon) * 50'(d_lon);
    s_tag <= q_tag;
    s_rad <= (2*SQ1_K)'(q_lat) + (2*SQ1_K)'(q_lon);
  end

  // First square root.
  logic               r1_vld  [SQ1_K+1];
  logic [SQ1_K+1:0]   r1_rem  [SQ1_K+1];
  logic [SQ1_K-1:0]   r1_root [SQ1_K+1];
  logic [2*SQ1_K-1:0] r1_rad  [SQ1_K+1];
  logic [TW-1:0]      r1_tag  [SQ1_K+1];

  assign r1_vld[0]  = s_vld;
  assign r1_rem[0]  = '0;
  assign r1_root[0] = '0;
  assign r1_rad[0]  = s_rad;
  assign r1_tag[0]  = s_tag;

  for (genvar j = 0; j < SQ1_K; j++) begin : g_sq1
    ngs_sqrt_cell #(.K(SQ1_K), .TW(TW)) u_step (
      .clk      (clk),
      .rst      (rst),
      .in_vld   (r1_vld[j]),
      .in_rem   (r1_rem[j]),
      .in_root  (r1_root[j]),
      .in_rad   (r1_rad[j]),
      .in_tag   (r1_tag[j]),
      .out_vld  (r1_vld[j+1]),
      .out_rem  (r1_rem[j+1]),
      .out_root (r1_root[j+1]),
      .out_rad  (r1_rad[j+1]),
      .out_tag  (r1_tag[j+1])
    );
  end

  // Lateral range, its square, and the slant radicand.
  logic [SQ1_K+16:0]  lm_prod;
  logic               lm_vld, lq_vld, a_vld;
  logic [TW-1:0]      lm_tag, lq_tag, a_tag;
  logic [26:0]        lm_val;
  logic [53:0]        lq_val;
  logic [2*SQ2_K-1:0] a_rad;

  assign lm_prod = (SQ1_K+17)'(r1_root[SQ1_K]) * (SQ1_K+17)'(METRES_PER_DEG);

  always_ff @(posedge clk) begin
    if (rst) begin
      lm_vld <= 1'b0;
      lq_vld <= 1'b0;
      a_vld  <= 1'b0;
    end else begin
      lm_vld <= r1_vld[SQ1_K];
      lq_vld <= lm_vld;
      a_vld  <= lq_vld;
    end
  end

  always_ff @(posedge clk) begin
    lm_tag <= r1_tag[SQ1_K];
    lm_val <= 27'(lm_prod >> DEG_FRAC_BITS);
    lq_tag <= lm_tag;
    lq_val <= 54'(lm_val) * 54'(lm_val);
    a_tag  <= lq_tag;
    a_rad  <= (2*SQ2_K)'(lq_val) + alt2;
  end

  // Second square root.
  logic               r2_vld  [SQ2_K+1];
  logic [SQ2_K+1:0]   r2_rem  [SQ2_K+1];
  logic [SQ2_K-1:0]   r2_root [SQ2_K+1];
  logic [2*SQ2_K-1:0] r2_rad  [SQ2_K+1];
  logic [TW-1:0]      r2_tag  [SQ2_K+1];

  assign r2_vld[0]  = a_vld;
  assign r2_rem[0]  = '0;
  assign r2_root[0] = '0;
  assign r2_rad[0]  = a_rad;
  assign r2_tag[0]  = a_tag;

  for (genvar j = 0; j < SQ2_K; j++) begin : g_sq2
    ngs_sqrt_cell #(.K(SQ2_K), .TW(TW)) u_step (
      .clk      (clk),
      .rst      (rst),
      .in_vld   (r2_vld[j]),
      .in_rem   (r2_rem[j]),
      .in_root  (r2_root[j]),
      .in_rad   (r2_rad[j]),
      .in_tag   (r2_tag[j]),
      .out_vld  (r2_vld[j+1]),
      .out_rem  (r2_rem[j+1]),
      .out_root (r2_root[j+1]),
      .out_rad  (r2_rad[j+1]),
      .out_tag  (r2_tag[j+1])
    );
  end

  // Minimum search.
  logic          found;
  logic [31:0]   best;
  logic [IW-1:0] best_idx;
  logic          take;
  logic          fin;
  logic          found_next;
  logic [31:0]   best_next;
  logic [IW-1:0] best_idx_next;
  logic [SQ2_K-1:0] slant;
  logic [TW-1:0]    c_tag;

  assign slant = r2_root[SQ2_K];
  assign c_tag = r2_tag[SQ2_K];
  assign take  = r2_vld[SQ2_K] && c_tag[IW] && (!found || (slant <= best));
  assign fin   = r2_vld[SQ2_K] && c_tag[IW+1];
  assign found_next    = found || take;
  assign best_next     = take ? slant : best;
  assign best_idx_next = take ? c_tag[IW-1:0] : best_idx;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      found <= 1'b0;
    end else begin
      found <= found_next;
    end
    best     <= best_next;
    best_idx <= best_idx_next;
  end

  // Control and held result.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      cnt          <= '0;
      last_time    <= '0;
      held_station <= '0;
      held_range   <= '0;
      m_tvalid     <= 1'b0;
      m_tdata      <= '0;
    end else begin
      if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_acc) begin
            if (req_type == REQ_QUERY && do_update) begin
              last_time <= query_time;
              cnt       <= '0;
              state     <= ST_SEARCH;
            end else begin
              m_tvalid <= 1'b1;
              m_tdata  <= {1'b0, held_range, held_station, 1'b0};
            end
          end
        end
        ST_SEARCH: begin
          cnt <= cnt + 1'b1;
          if (feed_last) begin
            cnt   <= '0;
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (fin) begin
            held_station <= found_next ? 6'(best_idx_next) : 6'd0;
            held_range   <= found_next ? best_next : 32'd0;
            m_tvalid     <= 1'b1;
            m_tdata      <= {1'b0, (found_next ? best_next : 32'd0),
                             (found_next ? 6'(best_idx_next) : 6'd0), 1'b1};
            state        <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_ready_only_idle: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> state == ST_IDLE)
    else $error("input taken while a search is in work");

  a_no_result_in_search: assert property (@(posedge clk) disable iff (rst)
    state != ST_IDLE |-> !m_tvalid)
    else $error("result pending during a search");

  a_feed_ends: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SEARCH && feed_last) |=> (state == ST_DRAIN && cnt == '0))
    else $error("ring rotation did not end after the last station");

  a_final_in_drain: assert property (@(posedge clk) disable iff (rst)
    fin |-> state == ST_DRAIN)
    else $error("last station left the pipeline outside the drain phase");

endmodule

[dv/tb.sv]
module tb;
  import ngs_pkg::*;

  typedef struct {
    logic        qry;
    logic [5:0]  idx;
    logic        act;
    logic [23:0] slat;
    logic [24:0] slon;
    logic [23:0] vlat;
    logic [24:0] vlon;
    logic [31:0] alt;
    logic [39:0] qtime;
  } req_t;

  typedef struct {
    logic        upd;
    logic [5:0]  stn;
    logic [31:0] rng;
  } res_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [0:0]   s_tuser = '0;
  logic [183:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [39:0]  m_tdata;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [15:0]  cfg_data = '0;

  req_t pending_reqs[$];
  res_t expected_results[$];
  int   errors = 0;
  int   gap_left = 0;
  int   burst_left = 0;
  int   stall_phase = 0;
  bit   hold_sender = 1'b0;
  bit   s_acc = 1'b0;

  // Shadow state of the station table and held search result.
  logic              st_act[NGS_STATIONS];
  logic signed [23:0] st_lat[NGS_STATIONS];
  logic signed [24:0] st_lon[NGS_STATIONS];
  logic [39:0]       last_upd;
  logic [5:0]        held_stn;
  logic [31:0]       held_rng;
  logic [15:0]       interval;

  nearest_ground_station_search_core i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  function automatic logic [63:0] int_sqrt(input logic [63:0] n);
    logic [63:0] root;
    logic [63:0] b;
    root = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= root + b) begin
        n = n - (root + b);
        root = (root >> 1) + b;
      end else begin
        root = root >> 1;
      end
      b = b >> 2;
    end
    return root;
  endfunction

  function automatic res_t search_station(input req_t r);
    res_t o;
    logic signed [63:0] d;
    logic [63:0] dla, dlo, lat_m, slant, aalt, best, alt2;
    logic found;
    o.upd = 1'b0;
    if (!r.qry) begin
      st_act[r.idx] = r.act;
      st_lat[r.idx] = r.slat;
      st_lon[r.idx] = r.slon;
    end else if ({24'd0, last_upd} + {48'd0, interval} < {24'd0, r.qtime}) begin
      d = $signed(r.alt);
      aalt = (d < 0) ? -d : d;
      alt2 = aalt * aalt;
      found = 1'b0;
      best = 0;
      held_stn = 0;
      for (int i = 0; i < NGS_STATIONS; i++) begin
        if (st_act[i]) begin
          d = 64'(st_lat[i]) - 64'($signed(r.vlat));
          dla = (d < 0) ? -d : d;
          d = 64'(st_lon[i]) - 64'($signed(r.vlon));
          dlo = (d < 0) ? -d : d;
          lat_m = (int_sqrt(dla * dla + dlo * dlo) * 64'd111123) >> DEG_FRAC_BITS;
          slant = int_sqrt(lat_m * lat_m + alt2);
          if (!found || slant <= best) begin
            found = 1'b1;
            best = slant;
            held_stn = 6'(i);
          end
        end
      end
      held_rng = best[31:0];
      last_upd = r.qtime;
      o.upd = 1'b1;
    end
    o.stn = held_stn;
    o.rng = held_rng;
    return o;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    errors++;
  endtask

  // Input handshake as seen at the rising edge.
  always @(posedge clk) begin
    s_acc <= s_tvalid && s_tready;
  end

  // Sender: bursts and gaps, fed from the pending queue.
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!(s_tvalid && !s_acc)) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        s_tvalid <= 1'b0;
      end else if (pending_reqs.size() > 0 && !hold_sender) begin
        req_t r;
        r = pending_reqs.pop_front();
        expected_results.push_back(search_station(r));
        s_tvalid <= 1'b1;
        s_tuser <= r.qry;
        s_tdata <= {7'd0, r.qtime, r.alt, r.vlon, r.vlat, r.slon, r.slat, r.act, r.idx};
        if (burst_left > 0) begin
          burst_left <= burst_left - 1;
        end else begin
          burst_left <= $urandom_range(0, 12);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver stall pattern.
  always @(negedge clk) begin
    stall_phase <= stall_phase + 1;
    if (stall_phase % 400 < 150) m_tready <= 1'b1;
    else m_tready <= ($urandom_range(0, 3) != 0);
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with no expectation");
      end else begin
        res_t e;
        e = expected_results.pop_front();
        if (m_tdata[0] !== e.upd)
          report_mismatch($sformatf("updated %0b exp %0b", m_tdata[0], e.upd));
        if (m_tdata[6:1] !== e.stn)
          report_mismatch($sformatf("station %0d exp %0d", m_tdata[6:1], e.stn));
        if (m_tdata[38:7] !== e.rng)
          report_mismatch($sformatf("range %0d exp %0d", m_tdata[38:7], e.rng));
      end
    end
  end

  function automatic logic [23:0] rand_lat();
    case ($urandom_range(0, 5))
      0: return 24'($signed(-5898240));
      1: return 24'd5898240;
      2: return 24'($urandom);
      default: return 24'($signed($urandom_range(0, 11796480)) - 5898240);
    endcase
  endfunction

  function automatic logic [24:0] rand_lon();
    case ($urandom_range(0, 5))
      0: return 25'($signed(-11796480));
      1: return 25'd11796480;
      2: return 25'($urandom);
      default: return 25'($signed($urandom_range(0, 23592960)) - 11796480);
    endcase
  endfunction

  function automatic req_t rand_write(input int idx);
    req_t r;
    r = '{default: '0};
    r.qry = REQ_WRITE;
    r.idx = 6'(idx);
    r.act = ($urandom_range(0, 3) != 0);
    r.slat = rand_lat();
    r.slon = rand_lon();
    r.vlat = 24'($urandom);
    r.vlon = 25'($urandom);
    r.alt = $urandom;
    r.qtime = {8'($urandom), 32'($urandom)};
    return r;
  endfunction

  function automatic req_t make_query(input logic [39:0] t);
    req_t r;
    r = '{default: '0};
    r.qry = REQ_QUERY;
    r.idx = 6'($urandom);
    r.act = 1'($urandom);
    r.slat = 24'($urandom);
    r.slon = 25'($urandom);
    r.vlat = rand_lat();
    r.vlon = rand_lon();
    case ($urandom_range(0, 4))
      0: r.alt = 32'h8000_0000;
      1: r.alt = 32'h7fff_ffff;
      2: r.alt = $urandom;
      default: r.alt = $urandom_range(0, 400000);
    endcase
    r.qtime = t;
    return r;
  endfunction

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || expected_results.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_interval(input logic [15:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    interval = v;
  endtask

  initial begin
    logic [39:0] t;
    req_t r;
    logic [15:0] settings[4];
    for (int i = 0; i < NGS_STATIONS; i++) begin
      st_act[i] = 1'b0;
      st_lat[i] = '0;
      st_lon[i] = '0;
    end
    last_upd = '0;
    held_stn = '0;
    held_rng = '0;
    interval = NGS_INTERVAL_RESET;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: query with no active station, boundary of the update test, extremes.
    pending_reqs.push_back(make_query(40'd1000));
    pending_reqs.push_back(make_query(40'd1001));
    pending_reqs.push_back(make_query(40'd2001));
    r = rand_write(0);
    r.act = 1'b1; r.slat = 24'($signed(-5898240)); r.slon = 25'($signed(-11796480));
    pending_reqs.push_back(r);
    r = rand_write(63);
    r.act = 1'b1; r.slat = 24'd5898240; r.slon = 25'd11796480;
    pending_reqs.push_back(r);
    r = rand_write(5);
    r.act = 1'b1; r.slat = 24'd5898240; r.slon = 25'd11796480;
    pending_reqs.push_back(r);
    r = make_query(40'd3100);
    r.vlat = 24'd5898240; r.vlon = 25'd11796480; r.alt = 32'h8000_0000;
    pending_reqs.push_back(r);
    r = make_query(40'd5000);
    r.vlat = 24'h800000; r.vlon = 25'h0ffffff; r.alt = 32'h7fff_ffff;
    pending_reqs.push_back(r);
    wait_drained();
    // Hold the sender with a query queued until everything is back.
    hold_sender = 1'b1;
    pending_reqs.push_back(make_query(40'd0));
    repeat (300) @(posedge clk);
    hold_sender = 1'b0;
    wait_drained();

    settings = '{16'd0, 16'hffff, 16'd1000, 16'd37};
    for (int ph = 0; ph < 4; ph++) begin
      write_interval(settings[ph]);
      // Each phase continues from the last recompute time.
      t = last_upd;
      for (int k = 0; k < 440; k++) begin
        if ($urandom_range(0, 2) == 0) begin
          pending_reqs.push_back(rand_write($urandom_range(0, 63)));
        end else begin
          case ($urandom_range(0, 3))
            0: t = t + interval;
            1: t = t + interval + 1;
            2: t = t + $urandom_range(0, 3);
            default: t = t + $urandom_range(0, 2 * interval + 2);
          endcase
          pending_reqs.push_back(make_query(t));
        end
      end
      wait_drained();
    end

    // The largest query time comes last, since it pins the last recompute time.
    pending_reqs.push_back(make_query(40'hff_ffff_ffff));
    pending_reqs.push_back(make_query(40'hff_ffff_ffff));
    wait_drained();

    if (errors == 0) begin
      $display("nearest_ground_station_search_core verification clean");
    end else begin
      $display("nearest_ground_station_search_core verification failed");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("nearest_ground_station_search_core verification failed");
    $finish;
  end

endmodule

[filelist.f]
src/ngs_pkg.sv
src/ngs_station_cell.sv
src/ngs_sqrt_cell.sv
src/nearest_ground_station_search_core.sv
dv/tb.sv
